>>> src/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/glsc_pkg.sv
`timescale 1ns / 1ps

package glsc_pkg;

   localparam int MAX_SIDE    = 32;
   localparam int SAMPLE_W    = 24;
   localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
   localparam int ADDR_W      = $clog2(MAX_SIDE);
   localparam int POS_W       = 5;
   localparam int VALUE_W     = 38;
   localparam int STENCIL_W   = SAMPLE_W + 3;
   localparam int SCALE_W     = 2 * SIDE_W + 1;
   localparam int PROD_W      = STENCIL_W + SCALE_W + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int SIDE_MIN    = 2;
   localparam int SIDE_RESET  = 10;
   localparam int SCALE_RESET = (SIDE_RESET + 1) * (SIDE_RESET + 1);

   // One classified sample on its way from the front end to the back end.
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [ADDR_W-1:0]   col;
      logic [POS_W-1:0]    out_row;
      logic                first_row;
      logic                has_up;
      logic                final_item;
   } cmd_type;

   typedef struct packed {
      logic [SIDE_W-1:0]  side;
      logic [SCALE_W-1:0] scale;
   } cfg_type;

endpackage

>>> src/glsc_ram.sv
`timescale 1ns / 1ps

module glsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/glsc_queue.sv
`timescale 1ns / 1ps

module glsc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  glsc_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output glsc_pkg::cmd_type head
);

   localparam int PTR_W = $clog2(glsc_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(glsc_pkg::QUEUE_DEPTH + 1);

   glsc_pkg::cmd_type entries_ff [glsc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(glsc_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(glsc_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full  = (count_ff == CNT_W'(glsc_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

endmodule

>>> src/glsc_front.sv
`timescale 1ns / 1ps

module glsc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [glsc_pkg::SIDE_W-1:0]       csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [glsc_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                              q_full,
   output logic                              push,
   output glsc_pkg::cmd_type                 push_data,
   output glsc_pkg::cfg_type                 cfg
);

   localparam int SW = glsc_pkg::SIDE_W;
   localparam int AW = glsc_pkg::ADDR_W;

   logic [SW-1:0]                  side_ff, side_in;
   logic [glsc_pkg::SCALE_W-1:0]   scale_ff, scale_in;
   logic [AW-1:0]                  row_ff, row_in;
   logic [AW-1:0]                  col_ff, col_in;

   logic [SW-1:0]     side_clamp;
   logic [SW:0]       side_p1;
   logic [2*SW+1:0]   side_sq;
   logic              final_item;
   logic              wrap;
   logic [AW-1:0]     r_eff, c_eff;
   logic [SW-1:0]     col_next;

   always_comb begin
      // Out-of-range sides are pinned to the legal range before use.
      if (csr_wr_data < SW'(glsc_pkg::SIDE_MIN)) begin
         side_clamp = SW'(glsc_pkg::SIDE_MIN);
      end else if (csr_wr_data > SW'(glsc_pkg::MAX_SIDE)) begin
         side_clamp = SW'(glsc_pkg::MAX_SIDE);
      end else begin
         side_clamp = csr_wr_data;
      end
      side_p1  = {1'b0, side_clamp} + 1'b1;
      side_sq  = {{(SW+1){1'b0}}, side_p1} * {{(SW+1){1'b0}}, side_p1};
      side_in  = csr_wr_en ? side_clamp : side_ff;
      scale_in = csr_wr_en ? side_sq[glsc_pkg::SCALE_W-1:0] : scale_ff;
   end

   always_comb begin
      final_item = (SW'(row_ff) == side_ff - 1'b1) && (SW'(col_ff) == side_ff - 1'b1);
      wrap       = (SW'(row_ff) >= side_ff) || (SW'(col_ff) >= side_ff);
      r_eff      = wrap ? '0 : row_ff;
      c_eff      = wrap ? '0 : col_ff;
      col_next   = SW'(c_eff) + 1'b1;

      push_data.sample     = req_sample;
      push_data.col        = c_eff;
      push_data.out_row    = glsc_pkg::POS_W'(r_eff - 1'b1);
      push_data.first_row  = (r_eff == '0);
      push_data.has_up     = (r_eff > AW'(1));
      push_data.final_item = final_item;

      push      = req_valid && !q_full;
      req_stall = q_full;

      row_in = row_ff;
      col_in = col_ff;
      if (csr_wr_en) begin
         // A register write restarts the grid at point (0, 0).
         row_in = '0;
         col_in = '0;
      end else if (push) begin
         if (final_item) begin
            row_in = '0;
            col_in = '0;
         end else if (col_next == side_ff) begin
            row_in = r_eff + 1'b1;
            col_in = '0;
         end else begin
            row_in = r_eff;
            col_in = AW'(col_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff  <= SW'(glsc_pkg::SIDE_RESET);
         scale_ff <= glsc_pkg::SCALE_W'(glsc_pkg::SCALE_RESET);
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         side_ff  <= side_in;
         scale_ff <= scale_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   assign cfg.side  = side_ff;
   assign cfg.scale = scale_ff;

endmodule

>>> src/glsc_back.sv
`timescale 1ns / 1ps

module glsc_back (
   input  logic                                clock,
   input  logic                                reset,
   input  glsc_pkg::cfg_type                   cfg,
   input  logic                                q_empty,
   input  glsc_pkg::cmd_type                   q_head,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [glsc_pkg::VALUE_W-1:0] rsp_laplacian_value,
   output logic [glsc_pkg::POS_W-1:0]          rsp_out_row,
   output logic [glsc_pkg::POS_W-1:0]          rsp_out_col,
   output logic                                rsp_run_last,
   output logic                                rsp_grid_end
);

   localparam int SW  = glsc_pkg::SIDE_W;
   localparam int AW  = glsc_pkg::ADDR_W;
   localparam int DW  = glsc_pkg::SAMPLE_W;
   localparam int STW = glsc_pkg::STENCIL_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_COMPUTE,
      ST_EMIT
   } state_type;

   state_type         state_ff, state_in;
   glsc_pkg::cmd_type cmd_ff, cmd_in;
   logic              flush_ff, flush_in;
   logic [DW-1:0]     left_ff, left_in;
   logic signed [STW-1:0] stencil_ff, stencil_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [glsc_pkg::VALUE_W-1:0]        rsp_value_ff, rsp_value_in;
   logic [glsc_pkg::POS_W-1:0]          rsp_row_ff, rsp_row_in;
   logic [glsc_pkg::POS_W-1:0]          rsp_col_ff, rsp_col_in;
   logic                                rsp_last_ff, rsp_last_in;
   logic                                rsp_end_ff, rsp_end_in;

   logic [DW-1:0] rd_ctr, rd_right, rd_up;
   logic [AW-1:0] right_addr;
   logic          wr_en;
   logic          has_right, last_col, out_free;

   logic signed [STW-1:0] ctr_e, left_e, right_e, up_e, x_e, stencil_sum;
   logic signed [glsc_pkg::SCALE_W:0] scale_s;
   logic signed [glsc_pkg::PROD_W-1:0] prod;

   // The centre row is kept twice so that a column and its right neighbour
   // can be read in the same cycle.
   assign right_addr = cmd_ff.col + 1'b1;
   assign wr_en      = (state_ff == ST_COMPUTE) && !flush_ff;

   glsc_ram #(.WIDTH(DW), .DEPTH(glsc_pkg::MAX_SIDE)) u_center_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cmd_ff.col),
      .wr_data (cmd_ff.sample),
      .rd_addr (cmd_ff.col),
      .rd_data (rd_ctr)
   );

   glsc_ram #(.WIDTH(DW), .DEPTH(glsc_pkg::MAX_SIDE)) u_center_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cmd_ff.col),
      .wr_data (cmd_ff.sample),
      .rd_addr (right_addr),
      .rd_data (rd_right)
   );

   glsc_ram #(.WIDTH(DW), .DEPTH(glsc_pkg::MAX_SIDE)) u_above (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cmd_ff.col),
      .wr_data (rd_ctr),
      .rd_addr (cmd_ff.col),
      .rd_data (rd_up)
   );

   always_comb begin
      has_right = (SW'(cmd_ff.col) + 1'b1) < cfg.side;
      last_col  = SW'(cmd_ff.col) == (cfg.side - 1'b1);
      out_free  = !rsp_valid_ff || !rsp_stall;

      ctr_e   = STW'($signed(rd_ctr));
      left_e  = (cmd_ff.col == '0) ? '0 : STW'($signed(left_ff));
      right_e = has_right ? STW'($signed(rd_right)) : '0;
      up_e    = cmd_ff.has_up ? STW'($signed(rd_up)) : '0;
      x_e     = STW'($signed(cmd_ff.sample));
      stencil_sum = (ctr_e <<< 2) - left_e - right_e - up_e - x_e;

      scale_s = {1'b0, cfg.scale};
      prod    = stencil_ff * scale_s;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      flush_in     = flush_ff;
      left_in      = left_ff;
      stencil_in   = stencil_ff;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_end_in   = rsp_end_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_head;
               flush_in = 1'b0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            state_in = ST_COMPUTE;
         end
         ST_COMPUTE: begin
            stencil_in = stencil_sum;
            left_in    = rd_ctr;
            if (!flush_ff && cmd_ff.first_row) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = prod[glsc_pkg::VALUE_W-1:0];
               rsp_row_in   = cmd_ff.out_row;
               rsp_col_in   = glsc_pkg::POS_W'(cmd_ff.col);
               if (flush_ff) begin
                  rsp_last_in = last_col;
                  rsp_end_in  = last_col;
                  if (last_col) begin
                     flush_in = 1'b0;
                     state_in = ST_IDLE;
                  end else begin
                     cmd_in.col = cmd_ff.col + 1'b1;
                     state_in   = ST_ISSUE;
                  end
               end else begin
                  rsp_last_in = !cmd_ff.final_item;
                  rsp_end_in  = 1'b0;
                  if (cmd_ff.final_item) begin
                     // The final sample is in; sweep the bottom row, which
                     // has no row below it.
                     flush_in          = 1'b1;
                     cmd_in.col        = '0;
                     cmd_in.out_row    = glsc_pkg::POS_W'(cfg.side - 1'b1);
                     cmd_in.sample     = '0;
                     cmd_in.has_up     = 1'b1;
                     cmd_in.first_row  = 1'b0;
                     cmd_in.final_item = 1'b0;
                     state_in          = ST_ISSUE;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      left_ff      <= left_in;
      stencil_ff   <= stencil_in;
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_laplacian_value = rsp_value_ff;
   assign rsp_out_row         = rsp_row_ff;
   assign rsp_out_col         = rsp_col_ff;
   assign rsp_run_last        = rsp_last_ff;
   assign rsp_grid_end        = rsp_end_ff;

endmodule

>>> src/grid_laplacian_stencil_core.sv
// The back end takes one sample at a time through its issue, compute and emit states, reading
// the single-read-port row stores, summing the stencil and multiplying by the scale; it pops no
// new sample until it is back in idle. First-row samples yield no result, and the final sample
// starts a sweep of the bottom row. A 4-word queue decouples input.
// Reset is synchronous and active high: counters, queue, sequencer and output valid clear,
// the grid side returns to 10, and the row stores keep whatever they held.
`timescale 1ns / 1ps

module grid_laplacian_stencil_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [glsc_pkg::SIDE_W-1:0]          csr_wr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [glsc_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [glsc_pkg::VALUE_W-1:0]  rsp_laplacian_value,
   output logic [glsc_pkg::POS_W-1:0]           rsp_out_row,
   output logic [glsc_pkg::POS_W-1:0]           rsp_out_col,
   output logic                                 rsp_run_last,
   output logic                                 rsp_grid_end
);

   glsc_pkg::cmd_type push_data, q_head;
   glsc_pkg::cfg_type cfg;
   logic              push, q_full, q_pop, q_empty;

   glsc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .q_full      (q_full),
      .push        (push),
      .push_data   (push_data),
      .cfg         (cfg)
   );

   glsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   glsc_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .q_empty             (q_empty),
      .q_head              (q_head),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_laplacian_value (rsp_laplacian_value),
      .rsp_out_row         (rsp_out_row),
      .rsp_out_col         (rsp_out_col),
      .rsp_run_last        (rsp_run_last),
      .rsp_grid_end        (rsp_grid_end)
   );

endmodule

>>> src/glsc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module glsc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [glsc_pkg::VALUE_W-1:0] rsp_laplacian_value,
   input logic [glsc_pkg::POS_W-1:0]          rsp_out_row,
   input logic [glsc_pkg::POS_W-1:0]          rsp_out_col,
   input logic                                rsp_run_last,
   input logic                                rsp_grid_end
);

   // A stalled result word keeps its value and position.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_laplacian_value) && $stable(rsp_out_row) && $stable(rsp_out_col), "stalled result word changed")

   // The end of a grid always closes the run of its input word.
   `ASSERT_CLK_RST(a_end_is_last, clock, reset, rsp_valid && rsp_grid_end |-> rsp_run_last, "grid end without run end")

   // The grid is square, so its final point sits on the diagonal.
   `ASSERT_CLK_RST(a_end_corner, clock, reset, rsp_valid && rsp_grid_end |-> rsp_out_row == rsp_out_col, "grid end off the corner")

   // Nothing is offered in the cycle after reset.
   `ASSERT_CLK(a_reset_quiet, clock, reset |=> !rsp_valid, "result word offered after reset")

endmodule

bind grid_laplacian_stencil_core glsc_checker u_checker (.*);
